// ===== hw/rtl/lob_pkg.sv =====
// Shared constants, stage types and step functions for the log barrier prox pipeline.
`timescale 1ns / 1ps
package lob_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int VAL_W      = 32;
   localparam int OUT_W      = 31;
   localparam int LAM_W      = 31;
   localparam int MAG_W      = 32;
   localparam int D_W        = 64;
   localparam int ROOT_W     = D_W / 2;
   localparam int SREM_W     = ROOT_W + 2;
   localparam int NUM_W      = LAM_W + 1 + FRAC_BITS;
   localparam int DIV_W      = ROOT_W + 2;
   localparam int SQ_STAGES  = ROOT_W;
   localparam int DV_STAGES  = NUM_W;
   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

   typedef struct packed {
      logic [D_W-1:0]    rad;
      logic [SREM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
      logic [MAG_W-1:0]  mag;
      logic              neg;
      logic              last;
      logic [LAM_W-1:0]  lam;
   } sq_stage_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DIV_W-1:0] rem;
      logic [NUM_W-1:0] quo;
      logic [DIV_W-1:0] dvsr;
      logic [MAG_W:0]   pos_x;
      logic             neg;
      logic             last;
   } dv_stage_type;

   // one result bit of the integer square root
   function automatic sq_stage_type sq_step(input sq_stage_type s);
      sq_stage_type     r;
      logic [SREM_W+1:0] part;
      logic [SREM_W+1:0] trial;
      r     = s;
      part  = {s.rem, s.rad[D_W-1 -: 2]};
      trial = {{(SREM_W-ROOT_W){1'b0}}, s.root, 2'b01};
      r.rad = {s.rad[D_W-3:0], 2'b00};
      if (part >= trial) begin
         r.rem  = SREM_W'(part - trial);
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = SREM_W'(part);
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // one quotient bit of restoring division
   function automatic dv_stage_type dv_step(input dv_stage_type s);
      dv_stage_type     r;
      logic [DIV_W:0]   part;
      r     = s;
      part  = {s.rem, s.num[NUM_W-1]};
      r.num = {s.num[NUM_W-2:0], 1'b0};
      if (part >= {1'b0, s.dvsr}) begin
         r.rem = DIV_W'(part - {1'b0, s.dvsr});
         r.quo = {s.quo[NUM_W-2:0], 1'b1};
      end else begin
         r.rem = DIV_W'(part);
         r.quo = {s.quo[NUM_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/lob_ifs.sv =====
// Request and response stream interfaces.
`timescale 1ns / 1ps
interface lob_req_if;
   logic                      valid;
   logic                      ready;
   logic [lob_pkg::VAL_W-1:0] point_value;
   logic                      last_in;
   modport source (output valid, point_value, last_in, input ready);
   modport sink   (input valid, point_value, last_in, output ready);
endinterface

interface lob_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lob_pkg::OUT_W-1:0] prox_value;
   logic                      last_out;
   logic                      saturated;
   modport source (output valid, prox_value, last_out, saturated, input ready);
   modport sink   (input valid, prox_value, last_out, saturated, output ready);
endinterface

// ===== hw/rtl/orthant_log_barrier_prox.sv =====
// Top level: pipelined proximal step of the log barrier on the nonnegative orthant.
// Beats pass through p0, p1, the square-root chain, the divide chain and the output register.
// One beat per cycle while the output is not stalled; the root and divide chains work one bit per stage.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous) clears all valid bits and sets lambda to 1.0.
`timescale 1ns / 1ps
module orthant_log_barrier_prox (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [lob_pkg::LAM_W-1:0] csr_wdata,
   lob_req_if.sink                   req,
   lob_rsp_if.source                 rsp
);
   import lob_pkg::*;

   logic [LAM_W-1:0] lam_ff;
   logic             adv;

   logic             p0_v_ff;
   logic [MAG_W-1:0] p0_mag_ff;
   logic             p0_neg_ff;
   logic             p0_last_ff;
   logic [LAM_W-1:0] p0_lam_ff;

   logic             p1_v_ff;
   logic [D_W-1:0]   p1_prod_ff;
   logic [MAG_W-1:0] p1_mag_ff;
   logic             p1_neg_ff;
   logic             p1_last_ff;
   logic [LAM_W-1:0] p1_lam_ff;

   sq_stage_type     sq_ff [SQ_STAGES+1];
   sq_stage_type     sq_in [SQ_STAGES+1];
   logic [SQ_STAGES:0] sq_v_ff;

   dv_stage_type     dv_ff [DV_STAGES+1];
   dv_stage_type     dv_in [DV_STAGES+1];
   logic [DV_STAGES:0] dv_v_ff;

   logic             out_v_ff;
   logic [OUT_W-1:0] out_x_ff;
   logic             out_last_ff;
   logic             out_sat_ff;

   logic [MAG_W-1:0] mag_in;
   logic [MAG_W:0]   fin_x;
   logic             fin_big;

   assign adv       = !out_v_ff || rsp.ready;
   assign req.ready = adv;

   // magnitude of t; the most negative value wraps to 2^31 exactly
   assign mag_in = req.point_value[VAL_W-1] ? (~req.point_value + 1'b1) : req.point_value;

   always_comb begin
      sq_in[0].rad  = p1_prod_ff + (D_W'(p1_lam_ff) << (FRAC_BITS + 2));
      sq_in[0].rem  = '0;
      sq_in[0].root = '0;
      sq_in[0].mag  = p1_mag_ff;
      sq_in[0].neg  = p1_neg_ff;
      sq_in[0].last = p1_last_ff;
      sq_in[0].lam  = p1_lam_ff;
      for (int k = 0; k < SQ_STAGES; k++) begin
         sq_in[k+1] = sq_step(sq_ff[k]);
      end
   end

   always_comb begin
      dv_in[0].num   = NUM_W'(sq_ff[SQ_STAGES].lam) << (FRAC_BITS + 1);
      dv_in[0].rem   = '0;
      dv_in[0].quo   = '0;
      dv_in[0].dvsr  = DIV_W'(sq_ff[SQ_STAGES].root) + DIV_W'(sq_ff[SQ_STAGES].mag);
      dv_in[0].pos_x = (MAG_W+1)'((33'(sq_ff[SQ_STAGES].root)
                                   + 33'(sq_ff[SQ_STAGES].mag)) >> 1);
      dv_in[0].neg   = sq_ff[SQ_STAGES].neg;
      dv_in[0].last  = sq_ff[SQ_STAGES].last;
      for (int k = 0; k < DV_STAGES; k++) begin
         dv_in[k+1] = dv_step(dv_ff[k]);
      end
   end

   always_comb begin
      if (dv_ff[DV_STAGES].neg) begin
         fin_big = |dv_ff[DV_STAGES].quo[NUM_W-1:OUT_W];
         fin_x   = (MAG_W+1)'(dv_ff[DV_STAGES].quo[OUT_W-1:0]);
      end else begin
         fin_big = |dv_ff[DV_STAGES].pos_x[MAG_W:OUT_W];
         fin_x   = dv_ff[DV_STAGES].pos_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lam_ff <= LAM_W'(65536);
      end else if (csr_we) begin
         lam_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_v_ff  <= 1'b0;
         p1_v_ff  <= 1'b0;
         sq_v_ff  <= '0;
         dv_v_ff  <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         p0_v_ff  <= req.valid;
         p1_v_ff  <= p0_v_ff;
         sq_v_ff  <= {sq_v_ff[SQ_STAGES-1:0], p1_v_ff};
         dv_v_ff  <= {dv_v_ff[DV_STAGES-1:0], sq_v_ff[SQ_STAGES]};
         out_v_ff <= dv_v_ff[DV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_mag_ff  <= mag_in;
         p0_neg_ff  <= req.point_value[VAL_W-1];
         p0_last_ff <= req.last_in;
         p0_lam_ff  <= lam_ff;
         p1_prod_ff <= p0_mag_ff * p0_mag_ff;
         p1_mag_ff  <= p0_mag_ff;
         p1_neg_ff  <= p0_neg_ff;
         p1_last_ff <= p0_last_ff;
         p1_lam_ff  <= p0_lam_ff;
         for (int k = 0; k <= SQ_STAGES; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         for (int k = 0; k <= DV_STAGES; k++) begin
            dv_ff[k] <= dv_in[k];
         end
         out_x_ff    <= fin_big ? OUT_MAX : fin_x[OUT_W-1:0];
         out_sat_ff  <= fin_big;
         out_last_ff <= dv_ff[DV_STAGES].last;
      end
   end

   assign rsp.valid      = out_v_ff;
   assign rsp.prox_value = out_x_ff;
   assign rsp.last_out   = out_last_ff;
   assign rsp.saturated  = out_sat_ff;

`ifndef SYNTH
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.saturated |-> rsp.prox_value == OUT_MAX)
      else $error("saturated beat without clipped value");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(sq_v_ff) && $stable(dv_v_ff))
      else $error("pipeline moved during stall");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> p0_v_ff)
      else $error("accepted beat lost at entry");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      adv && dv_v_ff[DV_STAGES] |=> rsp.valid)
      else $error("finished beat not presented");
`endif

endmodule

// ===== tb/orthant_log_barrier_prox_test.sv =====
// Self-checking testbench for the orthant log barrier prox pipeline.
`timescale 1ns / 1ps
module orthant_log_barrier_prox_test;
   import lob_pkg::*;

   typedef struct {
      logic [OUT_W-1:0] prox;
      logic             last;
      logic             sat;
   } prox_beat_type;

   class prox_scoreboard;
      logic [LAM_W-1:0] lambda;
      prox_beat_type    pending[$];
      int               mismatches;

      function new();
         lambda     = 31'd65536;
         mismatches = 0;
      endfunction

      function longint unsigned isqrt(longint unsigned v);
         longint unsigned res;
         longint unsigned b;
         res = 0;
         b   = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v   = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      // compute the expected beat for an accepted element
      function void note_point(logic [VAL_W-1:0] t, logic last);
         longint unsigned raw, mag, lam, d, s, x;
         logic            neg;
         prox_beat_type   e;
         raw = 64'(t);
         neg = t[VAL_W-1];
         mag = neg ? (64'h1_0000_0000 - raw) : raw;
         lam = 64'(lambda);
         d   = mag * mag + ((lam << 2) << FRAC_BITS);
         s   = isqrt(d);
         if (!neg) x = (mag + s) >> 1;
         else x = ((lam << 1) << FRAC_BITS) / (s + mag);
         e.sat = 1'b0;
         if (x > 64'(OUT_MAX)) begin
            x     = 64'(OUT_MAX);
            e.sat = 1'b1;
         end
         e.prox = x[OUT_W-1:0];
         e.last = last;
         pending.push_back(e);
      endfunction

      function void check_result(logic [OUT_W-1:0] prox, logic last, logic sat);
         prox_beat_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: prox=%h last=%b sat=%b", prox, last, sat);
            return;
         end
         e = pending.pop_front();
         if (e.prox !== prox || e.last !== last || e.sat !== sat) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp prox=%h last=%b sat=%b, got prox=%h last=%b sat=%b",
                        e.prox, e.last, e.sat, prox, last, sat);
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [LAM_W-1:0] csr_wdata;
   logic             quiet;
   int               idle_cycles;

   lob_req_if req ();
   lob_rsp_if rsp ();

   prox_scoreboard sb = new();

   orthant_log_barrier_prox i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req.sink),
      .rsp       (rsp.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // random backpressure on the result side
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 23);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_result(rsp.prox_value, rsp.last_out, rsp.saturated);
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_point(logic [VAL_W-1:0] t, logic last);
      while (!quiet && $urandom_range(99) < 23) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.point_value <= t;
      req.last_in     <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_point(t, last);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (90) @(posedge clock);
   endtask

   task automatic write_lambda(logic [LAM_W-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.lambda = v;
      @(posedge clock);
   endtask

   function automatic logic [VAL_W-1:0] rand_point();
      int unsigned k;
      k = $urandom_range(9);
      if (k < 4) return $urandom();
      if (k < 7) return VAL_W'($signed($urandom_range(262144)) - 131072);
      if (k == 7) return {1'b0, {(VAL_W-1){1'b1}}} - $urandom_range(3);
      if (k == 8) return {1'b1, {(VAL_W-1){1'b0}}} + $urandom_range(3);
      return VAL_W'($signed($urandom_range(4)) - 2);
   endfunction

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) begin
         if (i == n / 3) quiet = 1'b1;
         if (i == n / 3 + 60) quiet = 1'b0;
         if (i == n / 2) drain();
         send_point(rand_point(), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      logic [LAM_W-1:0] lam_set[7];
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_wdata       <= '0;
      req.valid       <= 1'b0;
      req.point_value <= '0;
      req.last_in     <= 1'b0;
      quiet           = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed extremes under the reset lambda of 1.0
      send_point(32'h0000_0000, 1'b0);
      send_point(32'h0000_0001, 1'b1);
      send_point(32'hFFFF_FFFF, 1'b0);
      send_point(32'h7FFF_FFFF, 1'b1);
      send_point(32'h8000_0000, 1'b0);
      send_point(32'h0001_0000, 1'b0);
      send_point(32'hFFFF_0000, 1'b1);
      send_point(32'h8000_0001, 1'b0);
      send_point(32'h5555_5555, 1'b1);
      send_point(32'hAAAA_AAAA, 1'b0);
      drain();

      lam_set[0] = 31'd0;
      lam_set[1] = OUT_MAX;
      lam_set[2] = 31'd1;
      lam_set[3] = LAM_W'($urandom());
      lam_set[4] = LAM_W'($urandom_range(1 << 20));
      lam_set[5] = 31'h2AAA_AAAA;
      lam_set[6] = 31'd65536;
      for (int p = 0; p < 7; p++) begin
         write_lambda(lam_set[p]);
         // zero lambda and the most negative t are worth a few fixed beats
         send_point(32'h8000_0000, 1'b1);
         send_point(32'h7FFF_FFFF, 1'b0);
         send_point(32'hFFFF_FFFF, 1'b1);
         run_random(270);
         drain();
      end

      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
